// ----- src/owbm_pkg.sv -----
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int REG_W         = 10;
  localparam int TIMER_W_DEF   = 10;
  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [2:0] REG_RST_LOW  = 3'd0;
  localparam logic [2:0] REG_PRES_WT  = 3'd1;
  localparam logic [2:0] REG_RST_REC  = 3'd2;
  localparam logic [2:0] REG_WR_LEAD  = 3'd3;
  localparam logic [2:0] REG_WR_HOLD  = 3'd4;
  localparam logic [2:0] REG_RD_LEAD  = 3'd5;
  localparam logic [2:0] REG_RD_SMPL  = 3'd6;
  localparam logic [2:0] REG_RD_REC   = 3'd7;

  localparam logic [REG_W-1:0] RST_LOW_DEF = 10'd500;
  localparam logic [REG_W-1:0] PRES_WT_DEF = 10'd70;
  localparam logic [REG_W-1:0] RST_REC_DEF = 10'd500;
  localparam logic [REG_W-1:0] WR_LEAD_DEF = 10'd10;
  localparam logic [REG_W-1:0] WR_HOLD_DEF = 10'd50;
  localparam logic [REG_W-1:0] RD_LEAD_DEF = 10'd5;
  localparam logic [REG_W-1:0] RD_SMPL_DEF = 10'd5;
  localparam logic [REG_W-1:0] RD_REC_DEF  = 10'd50;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [REG_W-1:0] rst_low;
    logic [REG_W-1:0] pres_wait;
    logic [REG_W-1:0] rst_rec;
    logic [REG_W-1:0] wr_lead;
    logic [REG_W-1:0] wr_hold;
    logic [REG_W-1:0] rd_lead;
    logic [REG_W-1:0] rd_sample;
    logic [REG_W-1:0] rd_rec;
  } owbm_cfg_t;

  typedef struct packed {
    logic       is_rst;
    logic       is_wr;
    logic       is_rd;
    logic [7:0] data;
    logic       line;
  } owbm_item_t;

  typedef struct packed {
    logic       valid;
    owbm_item_t item;
  } owbm_head_t;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_WAIT = 10'b00_0000_0100,
    PH_RST_REC  = 10'b00_0000_1000,
    PH_WR_LEAD  = 10'b00_0001_0000,
    PH_WR_HOLD  = 10'b00_0010_0000,
    PH_WR_REL   = 10'b00_0100_0000,
    PH_RD_LEAD  = 10'b00_1000_0000,
    PH_RD_WAIT  = 10'b01_0000_0000,
    PH_RD_REC   = 10'b10_0000_0000
  } owbm_phase_t;

endpackage

// ----- src/owbm_if.sv -----
// ----------------------------------------------------------------------------
// owbm_if
// Valid/ready channels of the 1-Wire bus master: tick words in, result words out.
// ----------------------------------------------------------------------------
interface owbm_in_if import owbm_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic       line_level;

  modport source(output valid, cmd, data_byte, line_level, input ready);
  modport sink(input valid, cmd, data_byte, line_level, output ready);
endinterface

interface owbm_out_if import owbm_pkg::*; ;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       ack_bit;
  logic [7:0] read_data;

  modport source(output valid, drive_low, busy_res, done_res, ack_bit, read_data,
                 input ready);
  modport sink(input valid, drive_low, busy_res, done_res, ack_bit, read_data,
               output ready);
endinterface

// ----- src/one_wire_bus_master_unit.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// Open-drain 1-Wire master paced by one tick word per bus microsecond.
// ----------------------------------------------------------------------------
// Each word on in_ch is one bus tick: a command (tick only, reset/presence,
// write byte, read byte), the byte to send and the sampled wire level. Every
// accepted word yields exactly one word on out_ch: drive_low for the wire,
// busy/done flags, the last presence sample and the read byte so far.
// A command is taken only when the sequencer is idle; otherwise ignored.
// The accepting edge writes the decode queue; the sequencer later pops the word
// and loads its result into the output register once out_ch can take it.
// One word per cycle while out_ch does not stall.
// A two-word queue sits between decode and sequencer; when out_ch stalls the
// sequencer holds and in_ch keeps accepting until the queue is full.
// Slot lengths come from eight APB registers at byte offsets 0..28; write them
// only while the master is idle. Reset (rst, synchronous) empties the queue,
// returns the sequencer to idle with the presence sample at 1 and restores
// the default slot timings.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit import owbm_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_W_DEF
) (
  input  logic               clk,
  input  logic               rst,
  owbm_in_if.sink            in_ch,
  owbm_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  owbm_cfg_t  cfg;
  owbm_head_t head;
  logic       pop;

  owbm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owbm_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  owbm_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |-> out_ch.busy_res)
    else $error("done without busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.drive_low |-> out_ch.busy_res)
    else $error("wire driven while idle");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> $past(out_ch.valid && !out_ch.ready))
    else $error("queue full without output stall");

  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("sequencer stepped on empty queue");

endmodule

// ----- src/owbm_cfg.sv -----
// ----------------------------------------------------------------------------
// owbm_cfg
// APB register file holding the eight slot timing registers.
// ----------------------------------------------------------------------------
module owbm_cfg import owbm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output owbm_cfg_t          cfg
);

  logic             wr_en;
  logic [2:0]       idx;
  logic [REG_W-1:0] wval;
  logic [REG_W-1:0] rval;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign wval   = pwdata[REG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rst_low   <= RST_LOW_DEF;
      cfg.pres_wait <= PRES_WT_DEF;
      cfg.rst_rec   <= RST_REC_DEF;
      cfg.wr_lead   <= WR_LEAD_DEF;
      cfg.wr_hold   <= WR_HOLD_DEF;
      cfg.rd_lead   <= RD_LEAD_DEF;
      cfg.rd_sample <= RD_SMPL_DEF;
      cfg.rd_rec    <= RD_REC_DEF;
    end else if (wr_en) begin
      unique case (idx)
        REG_RST_LOW: cfg.rst_low   <= wval;
        REG_PRES_WT: cfg.pres_wait <= wval;
        REG_RST_REC: cfg.rst_rec   <= wval;
        REG_WR_LEAD: cfg.wr_lead   <= wval;
        REG_WR_HOLD: cfg.wr_hold   <= wval;
        REG_RD_LEAD: cfg.rd_lead   <= wval;
        REG_RD_SMPL: cfg.rd_sample <= wval;
        REG_RD_REC:  cfg.rd_rec    <= wval;
        default:     cfg.rd_rec    <= cfg.rd_rec;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RST_LOW: rval = cfg.rst_low;
      REG_PRES_WT: rval = cfg.pres_wait;
      REG_RST_REC: rval = cfg.rst_rec;
      REG_WR_LEAD: rval = cfg.wr_lead;
      REG_WR_HOLD: rval = cfg.wr_hold;
      REG_RD_LEAD: rval = cfg.rd_lead;
      REG_RD_SMPL: rval = cfg.rd_sample;
      REG_RD_REC:  rval = cfg.rd_rec;
      default:     rval = '0;
    endcase
  end

  assign prdata = PDATA_W'(rval);

endmodule

// ----- src/owbm_front.sv -----
// ----------------------------------------------------------------------------
// owbm_front
// Accepts tick words, decodes the command and queues them for the sequencer.
// ----------------------------------------------------------------------------
module owbm_front import owbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  owbm_in_if.sink    in_ch,
  input  logic       pop,
  output owbm_head_t head
);

  owbm_item_t             q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;
  logic [QCNT_W-1:0]      count;
  logic                   push;
  logic                   do_pop;
  owbm_item_t             dec;

  always_comb begin
    dec.is_rst = 1'b0;
    dec.is_wr  = 1'b0;
    dec.is_rd  = 1'b0;
    dec.data   = in_ch.data_byte;
    dec.line   = in_ch.line_level;
    unique case (in_ch.cmd)
      CMD_TICK:  dec.is_rst = 1'b0;
      CMD_RESET: dec.is_rst = 1'b1;
      CMD_WRITE: dec.is_wr  = 1'b1;
      CMD_READ:  dec.is_rd  = 1'b1;
      default:   dec.is_rst = 1'b0;
    endcase
  end

  assign in_ch.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid & in_ch.ready;
  assign do_pop      = pop & (count != '0);
  assign head.valid  = (count != '0);
  assign head.item   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

endmodule

// ----- src/owbm_back.sv -----
// ----------------------------------------------------------------------------
// owbm_back
// Bus phase sequencer: one queued tick per cycle while out_ch does not stall, results in an output register.
// ----------------------------------------------------------------------------
module owbm_back import owbm_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_W_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  owbm_cfg_t  cfg,
  input  owbm_head_t head,
  output logic       pop,
  owbm_out_if.source out_ch
);

  localparam int EXT_W = (TIMER_WIDTH > REG_W) ? TIMER_WIDTH : REG_W;
  localparam logic [EXT_W-1:0] TMAX = EXT_W'((64'd1 << TIMER_WIDTH) - 64'd1);

  function automatic logic [TIMER_WIDTH-1:0] sat_ticks(input logic [REG_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e == '0) e = EXT_W'(1);
    if (e > TMAX) e = TMAX;
    return e[TIMER_WIDTH-1:0];
  endfunction

  owbm_phase_t            phase, phase_a, phase_next;
  logic [TIMER_WIDTH-1:0] timer, timer_a, t_dec, timer_next;
  logic [2:0]             bit_cnt, bc_a, bit_cnt_next;
  logic [7:0]             tx, tx_a, tx_next;
  logic [7:0]             rx, rx_next;
  logic                   ack, ack_next;
  logic                   drive, busy, done;
  logic                   step;

  assign step = head.valid & (~out_ch.valid | out_ch.ready);
  assign pop  = step;

  always_comb begin
    phase_a = phase;
    timer_a = timer;
    tx_a    = tx;
    bc_a    = bit_cnt;
    if (phase == PH_IDLE) begin
      priority if (head.item.is_rst) begin
        phase_a = PH_RST_LOW;
        timer_a = sat_ticks(cfg.rst_low);
      end else if (head.item.is_wr) begin
        phase_a = PH_WR_LEAD;
        timer_a = sat_ticks(cfg.wr_lead);
        tx_a    = head.item.data;
        bc_a    = '0;
      end else if (head.item.is_rd) begin
        phase_a = PH_RD_LEAD;
        timer_a = sat_ticks(cfg.rd_lead);
        bc_a    = '0;
      end
    end

    phase_next   = phase_a;
    timer_next   = timer_a;
    tx_next      = tx_a;
    bit_cnt_next = bc_a;
    rx_next      = rx;
    ack_next     = ack;
    drive        = 1'b0;
    busy         = 1'b0;
    done         = 1'b0;
    t_dec        = timer_a - TIMER_WIDTH'(timer_a != '0);

    if (phase_a != PH_IDLE) begin
      busy       = 1'b1;
      drive      = (phase_a == PH_RST_LOW) || (phase_a == PH_WR_LEAD) ||
                   (phase_a == PH_RD_LEAD) || ((phase_a == PH_WR_HOLD) && !tx_a[0]);
      timer_next = t_dec;
      if (t_dec == '0) begin
        unique case (phase_a)
          PH_RST_LOW: begin
            phase_next = PH_RST_WAIT;
            timer_next = sat_ticks(cfg.pres_wait);
          end
          PH_RST_WAIT: begin
            ack_next   = head.item.line;
            phase_next = PH_RST_REC;
            timer_next = sat_ticks(cfg.rst_rec);
          end
          PH_WR_LEAD: begin
            phase_next = PH_WR_HOLD;
            timer_next = sat_ticks(cfg.wr_hold);
          end
          PH_WR_HOLD: begin
            phase_next = PH_WR_REL;
            timer_next = TIMER_WIDTH'(1);
          end
          PH_WR_REL: begin
            tx_next = {1'b0, tx_a[7:1]};
            if (bc_a == LAST_BIT) begin
              bit_cnt_next = '0;
              phase_next   = PH_IDLE;
              done         = 1'b1;
            end else begin
              bit_cnt_next = bc_a + 3'd1;
              phase_next   = PH_WR_LEAD;
              timer_next   = sat_ticks(cfg.wr_lead);
            end
          end
          PH_RD_LEAD: begin
            phase_next = PH_RD_WAIT;
            timer_next = sat_ticks(cfg.rd_sample);
          end
          PH_RD_WAIT: begin
            rx_next    = {head.item.line, rx[7:1]};
            phase_next = PH_RD_REC;
            timer_next = sat_ticks(cfg.rd_rec);
          end
          PH_RD_REC: begin
            if (bc_a == LAST_BIT) begin
              bit_cnt_next = '0;
              phase_next   = PH_IDLE;
              done         = 1'b1;
            end else begin
              bit_cnt_next = bc_a + 3'd1;
              phase_next   = PH_RD_LEAD;
              timer_next   = sat_ticks(cfg.rd_lead);
            end
          end
          PH_RST_REC: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
            timer_next = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      timer   <= '0;
      bit_cnt <= '0;
      tx      <= '0;
      rx      <= '0;
      ack     <= 1'b1;
    end else if (step) begin
      phase   <= phase_next;
      timer   <= timer_next;
      bit_cnt <= bit_cnt_next;
      tx      <= tx_next;
      rx      <= rx_next;
      ack     <= ack_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (step) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_ch.drive_low <= drive;
      out_ch.busy_res  <= busy;
      out_ch.done_res  <= done;
      out_ch.ack_bit   <= ack_next;
      out_ch.read_data <= rx_next;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 1-Wire bus master unit.
// ----------------------------------------------------------------------------
// Tick words go in over a valid/ready channel with random gaps. The outgoing
// words are held off at random, with one long hold that backs up the input.
// A tick-level sequencer model predicts each result word of an untyped row. A short
// scripted run covers reset/presence, write and read slots, commands given
// while busy, and partial read bytes. Random runs follow under several slot
// timings: zero lengths and short random lengths, one run with no gaps on
// either side. Timing registers are reloaded over APB only while the master
// is idle and every result word has come back.
// ----------------------------------------------------------------------------
module testbench;
  import owbm_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int SCRIPT_LEN  = 23;

  typedef struct packed {
    logic       drive;
    logic       busy;
    logic       done;
    logic       ack;
    logic [7:0] rdata;
  } bus_out_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       line;
    logic [7:0] reps;
    logic       typed;
    bus_out_t   want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  owbm_in_if  in_ch();
  owbm_out_if out_ch();

  one_wire_bus_master_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // master model state
  logic [REG_W-1:0] slot_len [8];
  owbm_phase_t      m_phase = PH_IDLE;
  int unsigned      m_left  = 0;
  logic [2:0]       m_bit   = '0;
  logic [7:0]       m_tx    = '0;
  logic [7:0]       m_rx    = '0;
  logic             m_ack   = 1'b1;

  bus_out_t    due [$];
  int          errors = 0;
  int unsigned cycle_count = 0;
  bit          calm = 0;
  bit          squeeze_req = 0;

  script_row_t script [SCRIPT_LEN] = '{
    '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}},
    '{CMD_TICK,  8'hFF, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}},
    '{CMD_RESET, 8'h00, 1'b1, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
    '{CMD_WRITE, 8'hFF, 1'b0, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
    '{CMD_READ,  8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00}},
    '{CMD_RESET, 8'h00, 1'b1, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}},
    '{CMD_TICK,  8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00}},
    '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 8'h00}},
    '{CMD_WRITE, 8'hFF, 1'b1, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
    '{CMD_TICK,  8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00}},
    '{CMD_READ,  8'h00, 1'b0, 8'd22, 1'b0, '0},
    '{CMD_WRITE, 8'h00, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
    '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
    '{CMD_RESET, 8'h00, 1'b0, 8'd22, 1'b0, '0},
    '{CMD_READ,  8'h00, 1'b1, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
    '{CMD_TICK,  8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h80}},
    '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h80}},
    '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h80}},
    '{CMD_TICK,  8'h00, 1'b0, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h40}},
    '{CMD_TICK,  8'h00, 1'b1, 8'd19, 1'b0, '0},
    '{CMD_TICK,  8'hFF, 1'b0, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'hFD}},
    '{CMD_READ,  8'hFF, 1'b0, 8'd24, 1'b0, '0},
    '{CMD_TICK,  8'h00, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}}
  };

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic enter_phase(input owbm_phase_t p, input logic [REG_W-1:0] len);
    m_phase = p;
    m_left  = (len == '0) ? 1 : len;
  endtask

  task automatic step_master(input logic [1:0] cmd, input logic [7:0] data,
                             input logic line, output bus_out_t r);
    r = '0;
    if (m_phase == PH_IDLE) begin
      case (cmd)
        CMD_RESET: enter_phase(PH_RST_LOW, slot_len[REG_RST_LOW]);
        CMD_WRITE: begin
          m_tx  = data;
          m_bit = '0;
          enter_phase(PH_WR_LEAD, slot_len[REG_WR_LEAD]);
        end
        CMD_READ: begin
          m_bit = '0;
          enter_phase(PH_RD_LEAD, slot_len[REG_RD_LEAD]);
        end
        default: ;
      endcase
    end
    if (m_phase != PH_IDLE) begin
      r.busy = 1'b1;
      if (m_phase inside {PH_RST_LOW, PH_WR_LEAD, PH_RD_LEAD}) r.drive = 1'b1;
      else if (m_phase == PH_WR_HOLD) r.drive = ~m_tx[0];
      if (m_left > 0) m_left--;
      if (m_left == 0) begin
        case (m_phase)
          PH_RST_LOW:  enter_phase(PH_RST_WAIT, slot_len[REG_PRES_WT]);
          PH_RST_WAIT: begin
            m_ack = line;
            enter_phase(PH_RST_REC, slot_len[REG_RST_REC]);
          end
          PH_RST_REC: begin
            m_phase = PH_IDLE;
            r.done  = 1'b1;
          end
          PH_WR_LEAD:  enter_phase(PH_WR_HOLD, slot_len[REG_WR_HOLD]);
          PH_WR_HOLD:  enter_phase(PH_WR_REL, REG_W'(1));
          PH_WR_REL: begin
            m_tx = m_tx >> 1;
            if (m_bit == LAST_BIT) begin
              m_bit   = '0;
              m_phase = PH_IDLE;
              r.done  = 1'b1;
            end else begin
              m_bit++;
              enter_phase(PH_WR_LEAD, slot_len[REG_WR_LEAD]);
            end
          end
          PH_RD_LEAD:  enter_phase(PH_RD_WAIT, slot_len[REG_RD_SMPL]);
          PH_RD_WAIT: begin
            m_rx = {line, m_rx[7:1]};
            enter_phase(PH_RD_REC, slot_len[REG_RD_REC]);
          end
          PH_RD_REC: begin
            if (m_bit == LAST_BIT) begin
              m_bit   = '0;
              m_phase = PH_IDLE;
              r.done  = 1'b1;
            end else begin
              m_bit++;
              enter_phase(PH_RD_LEAD, slot_len[REG_RD_LEAD]);
            end
          end
          default: m_phase = PH_IDLE;
        endcase
      end
    end
    r.ack   = m_ack;
    r.rdata = m_rx;
  endtask

  // returns at the edge that accepts the word; valid stays high
  task automatic send_tick(input logic [1:0] cmd, input logic [7:0] data,
                           input logic line, input logic typed, input bus_out_t want);
    int gap;
    bus_out_t pred;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.data_byte  <= data;
    in_ch.line_level <= line;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    step_master(cmd, data, line, pred);
    due.push_back(typed ? want : pred);
  endtask

  // tick until the master is idle, then wait for every result word
  task automatic finish_command();
    while (m_phase != PH_IDLE) send_tick(CMD_TICK, 8'($urandom()), 1'($urandom()), 1'b0, '0);
    in_ch.valid <= 1'b0;
    while (due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [REG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    slot_len[idx] = val;
  endtask

  task automatic apb_park();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic retime(input int lo, input int hi);
    for (int i = 0; i < 8; i++) write_reg(3'(i), REG_W'($urandom_range(lo, hi)));
    apb_park();
  endtask

  task automatic random_run(input int n);
    logic [1:0] c;
    for (int i = 0; i < n; i++) begin
      if (m_phase == PH_IDLE)
        c = ($urandom_range(0, 99) < 75) ? 2'($urandom_range(1, 3)) : CMD_TICK;
      else
        c = ($urandom_range(0, 99) < 15) ? 2'($urandom_range(0, 3)) : CMD_TICK;
      send_tick(c, 8'($urandom()), 1'($urandom()), 1'b0, '0);
    end
    finish_command();
  endtask

  task automatic report_field(input string f, input int w, input int g);
    $display("%0t %s mismatch: expected %0h, got %0h", $time, f, w, g);
    errors++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    bus_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (due.size() == 0) begin
        $display("%0t unexpected result word: expected none, got %0h", $time,
                 {out_ch.drive_low, out_ch.busy_res, out_ch.done_res, out_ch.ack_bit,
                  out_ch.read_data});
        errors++;
      end else begin
        want = due.pop_front();
        if (out_ch.drive_low !== want.drive) report_field("drive_low", want.drive, out_ch.drive_low);
        if (out_ch.busy_res !== want.busy) report_field("busy_res", want.busy, out_ch.busy_res);
        if (out_ch.done_res !== want.done) report_field("done_res", want.done, out_ch.done_res);
        if (out_ch.ack_bit !== want.ack) report_field("ack_bit", want.ack, out_ch.ack_bit);
        if (out_ch.read_data !== want.rdata) report_field("read_data", want.rdata, out_ch.read_data);
      end
    end
  end

  // result side: random hold-offs plus one long hold on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        stall = idle_len();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    slot_len = '{RST_LOW_DEF, PRES_WT_DEF, RST_REC_DEF, WR_LEAD_DEF,
                 WR_HOLD_DEF, RD_LEAD_DEF, RD_SMPL_DEF, RD_REC_DEF};
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_TICK;
    in_ch.data_byte  <= '0;
    in_ch.line_level <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // shortest slots; zero lengths count as one tick
    retime(1, 1);
    write_reg(REG_WR_HOLD, '0);
    write_reg(REG_RD_REC, '0);
    apb_park();
    foreach (script[i])
      repeat (script[i].reps)
        send_tick(script[i].cmd, script[i].data, script[i].line, script[i].typed, script[i].want);
    finish_command();

    retime(1, 3);
    squeeze_req = 1;
    random_run(120);

    retime(0, 0);
    random_run(50);

    retime(1, 8);
    random_run(100);

    retime(1, 2);
    calm = 1;
    random_run(80);
    calm = 0;
    random_run(100);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
